/* rtl/a2b_pkg.sv */
`timescale 1ns / 1ps

package a2b_pkg;

  localparam int ByteW   = 8;
  localparam int CharW   = 7;
  localparam int SymW    = 5;
  localparam int CfgIdxW = 2;
  localparam int QDepth  = 2;
  localparam int QPtrW   = 1;
  localparam int QCntW   = 2;

  localparam logic [CfgIdxW-1:0] CFG_FIG_SHIFT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LET_SHIFT = 2'd1;

  localparam logic [SymW-1:0] FIG_SHIFT_RST = 5'd27;
  localparam logic [SymW-1:0] LET_SHIFT_RST = 5'd31;

  localparam logic MODE_LETTERS = 1'b0;
  localparam logic MODE_FIGURES = 1'b1;

  typedef struct packed {
    logic            vld;
    logic [SymW-1:0] code;
  } a2b_lookup_t;

  typedef struct packed {
    logic            has_shift;
    logic [SymW-1:0] shift_code;
    logic [SymW-1:0] char_code;
  } a2b_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } a2b_qstat_t;

  function automatic logic [SymW-1:0] alpha_code(input logic [4:0] pos);
    logic [SymW-1:0] c;
    unique case (pos)
      5'd1:    c = 5'h03;
      5'd2:    c = 5'h19;
      5'd3:    c = 5'h0e;
      5'd4:    c = 5'h09;
      5'd5:    c = 5'h01;
      5'd6:    c = 5'h0d;
      5'd7:    c = 5'h1a;
      5'd8:    c = 5'h14;
      5'd9:    c = 5'h06;
      5'd10:   c = 5'h0b;
      5'd11:   c = 5'h0f;
      5'd12:   c = 5'h12;
      5'd13:   c = 5'h1c;
      5'd14:   c = 5'h0c;
      5'd15:   c = 5'h18;
      5'd16:   c = 5'h16;
      5'd17:   c = 5'h17;
      5'd18:   c = 5'h0a;
      5'd19:   c = 5'h05;
      5'd20:   c = 5'h10;
      5'd21:   c = 5'h07;
      5'd22:   c = 5'h1e;
      5'd23:   c = 5'h13;
      5'd24:   c = 5'h1d;
      5'd25:   c = 5'h15;
      5'd26:   c = 5'h11;
      default: c = 5'h00;
    endcase
    return c;
  endfunction

  // Upper and lower case letters share one code.
  function automatic a2b_lookup_t letters_lookup(input logic [CharW-1:0] ch);
    a2b_lookup_t r;
    unique case (ch)
      7'd0:    r = '{vld: 1'b1, code: 5'h00};
      7'd10:   r = '{vld: 1'b1, code: 5'h02};
      7'd13:   r = '{vld: 1'b1, code: 5'h08};
      7'd32:   r = '{vld: 1'b1, code: 5'h04};
      default: begin
        r.vld  = ch[6] && (ch[4:0] >= 5'd1) && (ch[4:0] <= 5'd26);
        r.code = alpha_code(ch[4:0]);
      end
    endcase
    return r;
  endfunction

  function automatic a2b_lookup_t figures_lookup(input logic [CharW-1:0] ch);
    a2b_lookup_t r;
    r.vld = 1'b1;
    unique case (ch)
      7'd0:    r.code = 5'h00;
      7'd7:    r.code = 5'h05;
      7'd10:   r.code = 5'h02;
      7'd13:   r.code = 5'h08;
      7'd32:   r.code = 5'h04;
      7'd33:   r.code = 5'h0d;
      7'd34:   r.code = 5'h11;
      7'd35:   r.code = 5'h14;
      7'd36:   r.code = 5'h09;
      7'd38:   r.code = 5'h1a;
      7'd40:   r.code = 5'h0f;
      7'd41:   r.code = 5'h12;
      7'd44:   r.code = 5'h0c;
      7'd45:   r.code = 5'h03;
      7'd46:   r.code = 5'h1c;
      7'd47:   r.code = 5'h1d;
      7'd48:   r.code = 5'h16;
      7'd49:   r.code = 5'h17;
      7'd50:   r.code = 5'h13;
      7'd51:   r.code = 5'h01;
      7'd52:   r.code = 5'h0a;
      7'd53:   r.code = 5'h10;
      7'd54:   r.code = 5'h15;
      7'd55:   r.code = 5'h07;
      7'd56:   r.code = 5'h06;
      7'd57:   r.code = 5'h18;
      7'd58:   r.code = 5'h0e;
      7'd59:   r.code = 5'h1e;
      7'd63:   r.code = 5'h19;
      7'd92:   r.code = 5'h0b;
      default: begin
        r.vld  = 1'b0;
        r.code = 5'h00;
      end
    endcase
    return r;
  endfunction

endpackage

/* rtl/a2b_front.sv */
`timescale 1ns / 1ps

module a2b_front
  import a2b_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [ByteW-1:0]   in_tdata,
  input  logic               in_tuser,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [SymW-1:0]    cfg_data,
  input  a2b_qstat_t         q_stat,
  output logic               push,
  output a2b_entry_t         push_data
);

  logic            mode_r, mode_nxt;
  logic [SymW-1:0] fig_shift_r, let_shift_r;
  logic            accept, mode_eff;
  a2b_lookup_t     let_lk, fig_lk;

  assign in_tready = !q_stat.full;
  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;

  assign let_lk   = letters_lookup(in_tdata[CharW-1:0]);
  assign fig_lk   = figures_lookup(in_tdata[CharW-1:0]);
  assign mode_eff = in_tuser ? MODE_LETTERS : mode_r;

  always_comb begin
    mode_nxt             = mode_r;
    push                 = 1'b0;
    push_data.has_shift  = 1'b0;
    push_data.shift_code = fig_shift_r;
    push_data.char_code  = fig_lk.code;
    if (accept) begin
      mode_nxt = mode_eff;
      if (let_lk.vld && fig_lk.vld) begin
        push = 1'b1;
      end else if (fig_lk.vld) begin
        push                = 1'b1;
        push_data.has_shift = (mode_eff != MODE_FIGURES);
        mode_nxt            = MODE_FIGURES;
      end else if (let_lk.vld) begin
        push                 = 1'b1;
        push_data.has_shift  = (mode_eff != MODE_LETTERS);
        push_data.shift_code = let_shift_r;
        push_data.char_code  = let_lk.code;
        mode_nxt             = MODE_LETTERS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_LETTERS;
      fig_shift_r <= FIG_SHIFT_RST;
      let_shift_r <= LET_SHIFT_RST;
    end else begin
      mode_r <= mode_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FIG_SHIFT) begin
          fig_shift_r <= cfg_data;
        end else if (cfg_index == CFG_LET_SHIFT) begin
          let_shift_r <= cfg_data;
        end
      end
    end
  end

endmodule

/* rtl/a2b_queue.sv */
`timescale 1ns / 1ps

module a2b_queue
  import a2b_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  a2b_entry_t push_data,
  input  logic       pop,
  output a2b_entry_t rd_data,
  output a2b_qstat_t stat
);

  a2b_entry_t       mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] count_r;

  assign rd_data    = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == QCntW'(QDepth));
  assign stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/a2b_back.sv */
`timescale 1ns / 1ps

module a2b_back
  import a2b_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  a2b_entry_t       q_data,
  input  a2b_qstat_t       q_stat,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [ByteW-1:0] out_tdata,
  output logic             out_tlast
);

  logic            valid_r, valid_nxt;
  logic            pending_r, pending_nxt;
  logic [SymW-1:0] sym_r, sym_nxt;
  logic            last_r, last_nxt;
  logic [SymW-1:0] char_r, char_nxt;
  logic            load;

  assign load = !valid_r || out_tready;
  assign pop  = load && !pending_r && !q_stat.empty;

  always_comb begin
    valid_nxt   = valid_r;
    pending_nxt = pending_r;
    sym_nxt     = sym_r;
    last_nxt    = last_r;
    char_nxt    = char_r;
    if (load) begin
      if (pending_r) begin
        valid_nxt   = 1'b1;
        sym_nxt     = char_r;
        last_nxt    = 1'b1;
        pending_nxt = 1'b0;
      end else if (!q_stat.empty) begin
        valid_nxt = 1'b1;
        if (q_data.has_shift) begin
          sym_nxt     = q_data.shift_code;
          last_nxt    = 1'b0;
          pending_nxt = 1'b1;
          char_nxt    = q_data.char_code;
        end else begin
          sym_nxt  = q_data.char_code;
          last_nxt = 1'b1;
        end
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      pending_r <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      pending_r <= pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r  <= sym_nxt;
    last_r <= last_nxt;
    char_r <= char_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(ByteW - SymW){1'b0}}, sym_r};
  assign out_tlast  = last_r;

endmodule

/* rtl/ascii_to_baudot_encoder.sv */
`timescale 1ns / 1ps

// ITA2 (Baudot) encoder. Each text byte is masked to seven bits and turns into
// one 5-bit symbol, into a shift symbol followed by the character symbol when
// the character lives only in the mode that is not current, or into nothing
// when it has no code. A byte with in_tuser set starts a message in letters
// mode. The output register sends one symbol per cycle while out_tready is
// high, so a byte yields two symbols when it needs a shift and one otherwise;
// out_tlast marks the character symbol. Input bytes are taken every cycle
// while the two-entry queue between the classifier and the output stage has
// room, and each symbol passes through the queue and then the output register.
// The shift codes reset to 27 (figures) and 31 (letters) and may be rewritten
// through the cfg port while no byte is in flight.

module ascii_to_baudot_encoder
  import a2b_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [ByteW-1:0]   in_tdata,   // text_byte
  input  logic               in_tuser,   // message_start
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [ByteW-1:0]   out_tdata,  // symbol in bits 4:0, zeros above
  output logic               out_tlast,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [SymW-1:0]    cfg_data
);

  logic       push, pop;
  a2b_entry_t push_data, q_data;
  a2b_qstat_t q_stat;

  a2b_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  a2b_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_data   (q_data),
    .stat      (q_stat)
  );

  a2b_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_data     (q_data),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTH
  // A shift symbol that is taken is always followed at once by its character.
  a_shift_then_char : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast)
    else $error("shift symbol not followed by its character");

  // The classifier never writes into a full queue.
  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("queue written while full");

  // The output stage never pulls from an empty queue.
  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue read while empty");
`endif

endmodule

/* test/tb_ascii_to_baudot_encoder.sv */
`timescale 1ns / 1ps

module tb_ascii_to_baudot_encoder;
  import a2b_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_3 = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_WORDS = 230;
  localparam int MAX_REPORTS = 100;

  // Letter codes for A through Z, A in the lowest five bits.
  localparam logic [26*SymW-1:0] ALPHA_CODES = {
    5'h11, 5'h15, 5'h1d, 5'h13, 5'h1e, 5'h07, 5'h10, 5'h05, 5'h0a, 5'h17,
    5'h16, 5'h18, 5'h0c, 5'h1c, 5'h12, 5'h0f, 5'h0b, 5'h06, 5'h14, 5'h1a,
    5'h0d, 5'h01, 5'h09, 5'h0e, 5'h19, 5'h03
  };

  typedef enum int {
    PICK_LETTER,
    PICK_FIGURE,
    PICK_SHARED,
    PICK_ANY
  } char_pick_t;

  typedef struct packed {
    logic [ByteW-1:0] text;
    logic             start;
  } text_word_t;

  typedef struct packed {
    logic [SymW-1:0] code;
    logic            last;
  } ita2_symbol_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [ByteW-1:0]   in_tdata = '0;   // text_byte
  logic               in_tuser = 1'b0; // message_start
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [ByteW-1:0]   out_tdata;       // symbol, zeros above
  logic               out_tlast;       // last_of_run
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [SymW-1:0]    cfg_data = '0;

  text_word_t   bytes_to_send[$];
  ita2_symbol_t symbols_due[$];

  logic [SymW-1:0] fig_shift = FIG_SHIFT_RST;
  logic [SymW-1:0] let_shift = LET_SHIFT_RST;
  logic            cur_mode = MODE_LETTERS;

  int errors = 0;
  int words_sent = 0;
  int symbols_seen = 0;
  int shifts_seen = 0;
  int settings_used = 1;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int in_gap = 0;
  int out_stall = 0;

  ascii_to_baudot_encoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic letter_code(input logic [CharW-1:0] ch,
                                       output logic [SymW-1:0] code);
    code = '0;
    case (ch)
      7'd0:  code = 5'h00;
      7'd10: code = 5'h02;
      7'd13: code = 5'h08;
      7'd32: code = 5'h04;
      default: begin
        if (ch[6] && ch[4:0] >= 5'd1 && ch[4:0] <= 5'd26) begin
          code = ALPHA_CODES[SymW*(ch[4:0]-1) +: SymW];
        end else begin
          return 1'b0;
        end
      end
    endcase
    return 1'b1;
  endfunction

  function automatic logic figure_code(input logic [CharW-1:0] ch,
                                       output logic [SymW-1:0] code);
    code = '0;
    case (ch)
      7'd0:  code = 5'h00;
      7'd7:  code = 5'h05;
      7'd10: code = 5'h02;
      7'd13: code = 5'h08;
      7'd32: code = 5'h04;
      7'd33: code = 5'h0d;
      7'd34: code = 5'h11;
      7'd35: code = 5'h14;
      7'd36: code = 5'h09;
      7'd38: code = 5'h1a;
      7'd40: code = 5'h0f;
      7'd41: code = 5'h12;
      7'd44: code = 5'h0c;
      7'd45: code = 5'h03;
      7'd46: code = 5'h1c;
      7'd47: code = 5'h1d;
      7'd48: code = 5'h16;
      7'd49: code = 5'h17;
      7'd50: code = 5'h13;
      7'd51: code = 5'h01;
      7'd52: code = 5'h0a;
      7'd53: code = 5'h10;
      7'd54: code = 5'h15;
      7'd55: code = 5'h07;
      7'd56: code = 5'h06;
      7'd57: code = 5'h18;
      7'd58: code = 5'h0e;
      7'd59: code = 5'h1e;
      7'd63: code = 5'h19;
      7'd92: code = 5'h0b;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void expect_symbol(input logic [SymW-1:0] code, input logic last);
    ita2_symbol_t s;
    s.code = code;
    s.last = last;
    symbols_due.insert(symbols_due.size(), s);
  endfunction

  function automatic void encode_text_byte(input text_word_t w);
    logic [CharW-1:0] ch;
    logic [SymW-1:0]  lc;
    logic [SymW-1:0]  fc;
    logic             lv;
    logic             fv;
    ch = w.text[CharW-1:0];
    lv = letter_code(ch, lc);
    fv = figure_code(ch, fc);
    if (w.start) cur_mode = MODE_LETTERS;
    if (lv && fv) begin
      expect_symbol(fc, 1'b1);
    end else if (fv) begin
      if (cur_mode != MODE_FIGURES) begin
        expect_symbol(fig_shift, 1'b0);
        cur_mode = MODE_FIGURES;
      end
      expect_symbol(fc, 1'b1);
    end else if (lv) begin
      if (cur_mode != MODE_LETTERS) begin
        expect_symbol(let_shift, 1'b0);
        cur_mode = MODE_LETTERS;
      end
      expect_symbol(lc, 1'b1);
    end
  endfunction

  function automatic int pick_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [ByteW-1:0] pick_text_byte(input char_pick_t kind);
    logic [CharW-1:0] ch;
    logic [SymW-1:0]  code;
    logic             lv;
    logic             fv;
    if (kind == PICK_ANY) return ByteW'($urandom_range(0, 255));
    do begin
      ch = CharW'($urandom_range(0, 127));
      lv = letter_code(ch, code);
      fv = figure_code(ch, code);
    end while (!((kind == PICK_LETTER && lv && !fv) ||
                 (kind == PICK_FIGURE && fv && !lv) ||
                 (kind == PICK_SHARED && fv && lv)));
    return {($urandom_range(0, 4) == 0), ch};
  endfunction

  function automatic void queue_word(input logic [ByteW-1:0] text, input logic start);
    text_word_t w;
    w.text = text;
    w.start = start;
    bytes_to_send.insert(bytes_to_send.size(), w);
  endfunction

  // Mostly text-like messages that switch modes often, with some raw noise.
  function automatic void queue_messages(input int count);
    int         queued;
    int         len;
    int         r;
    logic       noise;
    char_pick_t kind;
    queued = 0;
    while (queued < count) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      noise = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (noise || r < 8) kind = PICK_ANY;
        else if (r < 50) kind = PICK_LETTER;
        else if (r < 85) kind = PICK_FIGURE;
        else kind = PICK_SHARED;
        queue_word(pick_text_byte(kind),
                   noise ? ($urandom_range(0, 1) == 1)
                         : (i == 0 || $urandom_range(0, 39) == 0));
      end
      queued += len;
    end
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (bytes_to_send.size() != 0 || in_tvalid || symbols_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [SymW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_FIG_SHIFT: fig_shift = val;
      CFG_LET_SHIFT: let_shift = val;
      default: ;
    endcase
  endtask

  task automatic run_phase(input int pct_in, input int pct_out);
    settings_used++;
    in_idle_pct = pct_in;
    out_idle_pct = pct_out;
    queue_messages(PHASE_WORDS);
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= 1'b0;
      in_gap = 0;
    end else begin
      text_word_t w;
      if (in_tvalid && in_tready) begin
        w.text = in_tdata;
        w.start = in_tuser;
        encode_text_byte(w);
        words_sent++;
        in_gap = pick_gap(in_idle_pct);
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (bytes_to_send.size() != 0) begin
          w = bytes_to_send.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= w.text;
          in_tuser <= w.start;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall = 0;
    end else begin
      ita2_symbol_t e;
      if (out_tvalid && out_tready) begin
        symbols_seen++;
        if (!out_tlast) shifts_seen++;
        if (symbols_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: unexpected word: expected none, got symbol %0d last %0b",
                     $time, out_tdata, out_tlast);
          end
        end else begin
          e = symbols_due.pop_front();
          if (out_tdata != {{(ByteW-SymW){1'b0}}, e.code} || out_tlast != e.last) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("%0t: mismatch: expected symbol %0d last %0b, got symbol %0d last %0b",
                       $time, e.code, e.last, out_tdata, out_tlast);
            end
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_stall = pick_gap(out_idle_pct);
        out_tready <= (out_stall == 0);
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset shift codes, every special case, bit 7 set and message restarts.
    queue_word("H", 1'b1);
    queue_word("e", 1'b0);
    queue_word("1", 1'b0);
    queue_word("2", 1'b0);
    queue_word(" ", 1'b0);
    queue_word(8'h0a, 1'b0);
    queue_word(8'h0d, 1'b0);
    queue_word(8'h00, 1'b0);
    queue_word(8'h07, 1'b0);
    queue_word(8'h5c, 1'b0);
    queue_word("?", 1'b0);
    queue_word("Z", 1'b0);
    queue_word(8'h7b, 1'b0);
    queue_word(8'hff, 1'b0);
    queue_word(8'h80, 1'b0);
    queue_word(8'hc1, 1'b0);
    queue_word(8'hb3, 1'b0);
    queue_word("Q", 1'b1);
    queue_word("9", 1'b0);
    queue_word("-", 1'b1);
    queue_word("%", 1'b0);
    queue_word("x", 1'b0);
    queue_word(8'h7f, 1'b1);
    wait_idle();

    write_reg(CFG_FIG_SHIFT, 5'd0);
    write_reg(CFG_LET_SHIFT, 5'd31);
    run_phase(0, 0);
    write_reg(CFG_FIG_SHIFT, 5'd31);
    write_reg(CFG_LET_SHIFT, 5'd0);
    run_phase(30, 30);
    write_reg(CFG_SPARE_2, SymW'($urandom_range(0, 31)));
    write_reg(CFG_SPARE_3, SymW'($urandom_range(0, 31)));
    run_phase(60, 10);
    write_reg(CFG_FIG_SHIFT, SymW'($urandom_range(0, 31)));
    write_reg(CFG_LET_SHIFT, SymW'($urandom_range(0, 31)));
    run_phase(10, 60);
    write_reg(CFG_FIG_SHIFT, FIG_SHIFT_RST);
    write_reg(CFG_LET_SHIFT, LET_SHIFT_RST);
    run_phase(40, 40);
    write_reg(CFG_FIG_SHIFT, 5'd0);
    write_reg(CFG_LET_SHIFT, 5'd0);
    run_phase(20, 0);

    $display("Sent %0d text bytes over %0d phases of shift codes and idling.",
             words_sent, settings_used);
    $display("Checked %0d symbols, %0d of them shift codes; %0d errors.",
             symbols_seen, shifts_seen, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d symbols still expected.", symbols_due.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
